>>> rtl/cpl_pkg.sv
// Shared widths, constants and register codes for the closest-points block.
`default_nettype none
package cpl_pkg;
   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 16;
   localparam int RW          = COORD_WIDTH + 1;
   localparam int MW          = 2 * COORD_WIDTH + 4;
   localparam int MH          = MW / 2;
   localparam int PW          = 2 * MW;
   localparam int DW          = PW + 1;
   localparam int RMW         = DW + COORD_WIDTH;
   localparam int THR_WIDTH   = 31;
   localparam int CSR_AW      = 3;
   localparam int CSR_DW      = 32;

   localparam logic [THR_WIDTH-1:0]   THR_RESET     = THR_WIDTH'(1);
   localparam logic [CSR_AW-3:0]      REG_THRESHOLD = '0;
   localparam logic [COORD_WIDTH-1:0] SAT_MAX       = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic [COORD_WIDTH-1:0] SAT_MIN       = {1'b1, {(COORD_WIDTH-1){1'b0}}};
endpackage
`default_nettype wire

>>> rtl/cpl_req_if.sv
// Request channel carrying two lines, each a point and a direction.
`default_nettype none
interface cpl_req_if;
   logic valid;
   logic ready;
   logic signed [cpl_pkg::COORD_WIDTH-1:0] first_point_x;
   logic signed [cpl_pkg::COORD_WIDTH-1:0] first_point_y;
   logic signed [cpl_pkg::COORD_WIDTH-1:0] first_point_z;
   logic signed [cpl_pkg::COORD_WIDTH-1:0] first_dir_x;
   logic signed [cpl_pkg::COORD_WIDTH-1:0] first_dir_y;
   logic signed [cpl_pkg::COORD_WIDTH-1:0] first_dir_z;
   logic signed [cpl_pkg::COORD_WIDTH-1:0] second_point_x;
   logic signed [cpl_pkg::COORD_WIDTH-1:0] second_point_y;
   logic signed [cpl_pkg::COORD_WIDTH-1:0] second_point_z;
   logic signed [cpl_pkg::COORD_WIDTH-1:0] second_dir_x;
   logic signed [cpl_pkg::COORD_WIDTH-1:0] second_dir_y;
   logic signed [cpl_pkg::COORD_WIDTH-1:0] second_dir_z;

   modport source (output valid, first_point_x, first_point_y, first_point_z,
                   first_dir_x, first_dir_y, first_dir_z, second_point_x,
                   second_point_y, second_point_z, second_dir_x, second_dir_y,
                   second_dir_z, input ready);
   modport sink (input valid, first_point_x, first_point_y, first_point_z,
                 first_dir_x, first_dir_y, first_dir_z, second_point_x,
                 second_point_y, second_point_z, second_dir_x, second_dir_y,
                 second_dir_z, output ready);
endinterface
`default_nettype wire

>>> rtl/cpl_rsp_if.sv
// Response channel carrying the two closest-point parameters and flags.
`default_nettype none
interface cpl_rsp_if;
   logic valid;
   logic ready;
   logic signed [cpl_pkg::COORD_WIDTH-1:0] param_first;
   logic signed [cpl_pkg::COORD_WIDTH-1:0] param_second;
   logic is_parallel;
   logic overflowed;

   modport source (output valid, param_first, param_second, is_parallel, overflowed,
                   input ready);
   modport sink (input valid, param_first, param_second, is_parallel, overflowed,
                 output ready);
endinterface
`default_nettype wire

>>> rtl/cpl_mul.sv
// Three-stage signed wide multiplier built from four half-width partial products.
`default_nettype none
module cpl_mul (
   input  wire logic                            clock,
   input  wire logic                            en,
   input  wire logic signed [cpl_pkg::MW-1:0]   a,
   input  wire logic signed [cpl_pkg::MW-1:0]   b,
   output logic signed [cpl_pkg::PW-1:0]        p
);
   logic        [cpl_pkg::MH-1:0]   al, bl;
   logic signed [cpl_pkg::MH-1:0]   ah, bh;
   logic        [2*cpl_pkg::MH-1:0] pp0_in, pp0_ff, pp0b_ff;
   logic signed [2*cpl_pkg::MH:0]   pp1_in, pp1_ff, pp2_in, pp2_ff;
   logic signed [2*cpl_pkg::MH-1:0] pp3_in, pp3_ff, pp3b_ff;
   logic signed [2*cpl_pkg::MH+1:0] cross_in, cross_ff;
   logic signed [cpl_pkg::PW-1:0]   p_in, p_ff, hilo, crs;

   always_comb begin
      al     = a[cpl_pkg::MH-1:0];
      bl     = b[cpl_pkg::MH-1:0];
      ah     = a[cpl_pkg::MW-1:cpl_pkg::MH];
      bh     = b[cpl_pkg::MW-1:cpl_pkg::MH];
      pp0_in = al * bl;
      pp1_in = $signed({1'b0, al}) * bh;
      pp2_in = $signed({1'b0, bl}) * ah;
      pp3_in = ah * bh;
   end

   always_comb begin
      cross_in = (2*cpl_pkg::MH+2)'(pp1_ff) + (2*cpl_pkg::MH+2)'(pp2_ff);
   end

   always_comb begin
      hilo = $signed({pp3b_ff, pp0b_ff});
      crs  = cpl_pkg::PW'(cross_ff);
      p_in = hilo + (crs <<< cpl_pkg::MH);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pp0_ff   <= pp0_in;
         pp1_ff   <= pp1_in;
         pp2_ff   <= pp2_in;
         pp3_ff   <= pp3_in;
         pp0b_ff  <= pp0_ff;
         pp3b_ff  <= pp3_ff;
         cross_ff <= cross_in;
         p_ff     <= p_in;
      end
   end

   assign p = p_ff;
endmodule
`default_nettype wire

>>> rtl/closest_points_two_lines_top.sv
// Top level: pipelined closest points between two 3-D lines with APB threshold register.
//
// Closest points between two lines, Q16.16 in and out. A request enters every
// cycle unless the pipeline holds. Each request passes through one stage for
// the point difference, two for the dot products, three for each wide
// multiplier, one for the determinant and numerators, one range check, one to
// load the restoring divider and one stage per quotient bit (32), then the
// output register. The whole pipeline holds while a response waits; req.ready
// is low only then.
// Write parallel_threshold (byte address 0) only while no request is in flight.
`default_nettype none
module closest_points_two_lines_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   cpl_req_if.sink                            req,
   cpl_rsp_if.source                          rsp,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [cpl_pkg::CSR_AW-1:0]    paddr,
   input  wire logic [cpl_pkg::CSR_DW-1:0]    pwdata,
   output logic      [cpl_pkg::CSR_DW-1:0]    prdata,
   output logic                               pready
);
   localparam int CW = cpl_pkg::COORD_WIDTH;
   localparam int FB = cpl_pkg::FRAC_BITS;

   typedef struct packed {
      logic [cpl_pkg::RMW-1:0] rem1;
      logic [cpl_pkg::RMW-1:0] rem2;
      logic [cpl_pkg::RMW-1:0] den;
      logic [CW-1:0]           q1;
      logic [CW-1:0]           q2;
      logic                    neg1;
      logic                    neg2;
      logic                    big1;
      logic                    big2;
      logic                    par;
      logic                    par_ovf;
      logic [CW-1:0]           par_t2;
   } div_type;

   logic en;
   logic [cpl_pkg::THR_WIDTH-1:0] thr_ff;
   logic csr_wr;

   logic v1_ff, v2_ff, v3_ff, v7_ff, v8_ff;
   logic [2:0] vm_ff;
   logic signed [cpl_pkg::RW-1:0] r_ff [3];
   logic signed [CW-1:0] d1_ff [3], d2_ff [3];
   logic signed [2*CW-1:0] p11_ff [3], p12_ff [3], p22_ff [3];
   logic signed [2*CW:0] p1r_ff [3], p2r_ff [3];
   logic signed [cpl_pkg::MW-1:0] d11_ff, d12_ff, d22_ff, r1_ff, r2_ff;
   logic signed [cpl_pkg::MW-1:0] r2m_ff [3];
   logic signed [cpl_pkg::MW-1:0] r2_7_ff;
   logic signed [cpl_pkg::PW-1:0] m0, m1, m2, m3, m4, m5;
   logic signed [cpl_pkg::DW-1:0] det_ff, n1_ff, n2_ff;

   logic signed [cpl_pkg::DW-1:0] lim;
   logic [cpl_pkg::DW-1:0] mag1, mag2;
   logic signed [cpl_pkg::MW-1:0] r2b;
   logic par8_ff, neg1_8_ff, neg2_8_ff;
   logic [cpl_pkg::RMW-1:0] num1_ff, num2_ff, den8_ff;
   logic signed [cpl_pkg::MW-1:0] tq_ff;

   div_type div_ff [CW+1];
   div_type div_in [CW+1];
   logic    dv_ff  [CW+1];

   logic rsp_valid_ff;
   logic signed [CW-1:0] t1_in, t2_in, t1_ff, t2_ff;
   logic par_ff, ovf_in, ovf_ff;
   logic [CW-1:0] q1f, q2f;

   assign en        = !rsp_valid_ff || rsp.ready;
   assign req.ready = en;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite &&
                   (paddr[cpl_pkg::CSR_AW-1:2] == cpl_pkg::REG_THRESHOLD);
   assign prdata = (paddr[cpl_pkg::CSR_AW-1:2] == cpl_pkg::REG_THRESHOLD) ?
                   cpl_pkg::CSR_DW'(thr_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= cpl_pkg::THR_RESET;
      end else if (csr_wr) begin
         thr_ff <= pwdata[cpl_pkg::THR_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         vm_ff        <= '0;
         v7_ff        <= 1'b0;
         v8_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v1_ff        <= req.valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         vm_ff        <= {vm_ff[1:0], v3_ff};
         v7_ff        <= vm_ff[2];
         v8_ff        <= v7_ff;
         rsp_valid_ff <= dv_ff[CW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff[0]  <= cpl_pkg::RW'(req.first_point_x) - cpl_pkg::RW'(req.second_point_x);
         r_ff[1]  <= cpl_pkg::RW'(req.first_point_y) - cpl_pkg::RW'(req.second_point_y);
         r_ff[2]  <= cpl_pkg::RW'(req.first_point_z) - cpl_pkg::RW'(req.second_point_z);
         d1_ff[0] <= req.first_dir_x;
         d1_ff[1] <= req.first_dir_y;
         d1_ff[2] <= req.first_dir_z;
         d2_ff[0] <= req.second_dir_x;
         d2_ff[1] <= req.second_dir_y;
         d2_ff[2] <= req.second_dir_z;
         for (int i = 0; i < 3; i++) begin
            p11_ff[i] <= d1_ff[i] * d1_ff[i];
            p12_ff[i] <= d1_ff[i] * d2_ff[i];
            p22_ff[i] <= d2_ff[i] * d2_ff[i];
            p1r_ff[i] <= (2*CW+1)'(d1_ff[i]) * (2*CW+1)'(r_ff[i]);
            p2r_ff[i] <= (2*CW+1)'(d2_ff[i]) * (2*CW+1)'(r_ff[i]);
         end
         d11_ff <= cpl_pkg::MW'(p11_ff[0]) + cpl_pkg::MW'(p11_ff[1]) + cpl_pkg::MW'(p11_ff[2]);
         d12_ff <= cpl_pkg::MW'(p12_ff[0]) + cpl_pkg::MW'(p12_ff[1]) + cpl_pkg::MW'(p12_ff[2]);
         d22_ff <= cpl_pkg::MW'(p22_ff[0]) + cpl_pkg::MW'(p22_ff[1]) + cpl_pkg::MW'(p22_ff[2]);
         r1_ff  <= cpl_pkg::MW'(p1r_ff[0]) + cpl_pkg::MW'(p1r_ff[1]) + cpl_pkg::MW'(p1r_ff[2]);
         r2_ff  <= cpl_pkg::MW'(p2r_ff[0]) + cpl_pkg::MW'(p2r_ff[1]) + cpl_pkg::MW'(p2r_ff[2]);
         r2m_ff[0] <= r2_ff;
         r2m_ff[1] <= r2m_ff[0];
         r2m_ff[2] <= r2m_ff[1];
         det_ff  <= cpl_pkg::DW'(m0) - cpl_pkg::DW'(m1);
         n1_ff   <= cpl_pkg::DW'(m2) - cpl_pkg::DW'(m3);
         n2_ff   <= cpl_pkg::DW'(m4) - cpl_pkg::DW'(m5);
         r2_7_ff <= r2m_ff[2];
      end
   end

   cpl_mul u_mul_det_a (.clock(clock), .en(en), .a(d11_ff), .b(d22_ff), .p(m0));
   cpl_mul u_mul_det_b (.clock(clock), .en(en), .a(d12_ff), .b(d12_ff), .p(m1));
   cpl_mul u_mul_n1_a  (.clock(clock), .en(en), .a(d12_ff), .b(r2_ff),  .p(m2));
   cpl_mul u_mul_n1_b  (.clock(clock), .en(en), .a(d22_ff), .b(r1_ff),  .p(m3));
   cpl_mul u_mul_n2_a  (.clock(clock), .en(en), .a(d11_ff), .b(r2_ff),  .p(m4));
   cpl_mul u_mul_n2_b  (.clock(clock), .en(en), .a(d12_ff), .b(r1_ff),  .p(m5));

   always_comb begin
      lim  = $signed(cpl_pkg::DW'(thr_ff) << (3*FB));
      mag1 = n1_ff[cpl_pkg::DW-1] ? cpl_pkg::DW'(-n1_ff) : cpl_pkg::DW'(n1_ff);
      mag2 = n2_ff[cpl_pkg::DW-1] ? cpl_pkg::DW'(-n2_ff) : cpl_pkg::DW'(n2_ff);
      r2b  = r2_7_ff + (r2_7_ff[cpl_pkg::MW-1] ? cpl_pkg::MW'((1 << FB) - 1)
                                              : cpl_pkg::MW'(0));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         par8_ff   <= !(det_ff > lim);
         neg1_8_ff <= n1_ff[cpl_pkg::DW-1];
         neg2_8_ff <= n2_ff[cpl_pkg::DW-1];
         num1_ff   <= cpl_pkg::RMW'(mag1) << FB;
         num2_ff   <= cpl_pkg::RMW'(mag2) << FB;
         den8_ff   <= cpl_pkg::RMW'(det_ff[cpl_pkg::DW-1:0]);
         tq_ff     <= r2b >>> FB;
      end
   end

   always_comb begin
      div_in[0].rem1    = num1_ff;
      div_in[0].rem2    = num2_ff;
      div_in[0].den     = den8_ff;
      div_in[0].q1      = '0;
      div_in[0].q2      = '0;
      div_in[0].neg1    = neg1_8_ff;
      div_in[0].neg2    = neg2_8_ff;
      div_in[0].big1    = num1_ff >= (den8_ff << CW);
      div_in[0].big2    = num2_ff >= (den8_ff << CW);
      div_in[0].par     = par8_ff;
      div_in[0].par_ovf = !((&tq_ff[cpl_pkg::MW-1:CW-1]) || !(|tq_ff[cpl_pkg::MW-1:CW-1]));
      if (div_in[0].par_ovf) begin
         div_in[0].par_t2 = tq_ff[cpl_pkg::MW-1] ? cpl_pkg::SAT_MIN : cpl_pkg::SAT_MAX;
      end else begin
         div_in[0].par_t2 = tq_ff[CW-1:0];
      end
   end

   for (genvar g = 0; g < CW; g++) begin : g_div
      localparam int SH = CW - 1 - g;
      logic [cpl_pkg::RMW-1:0] sub;
      logic ge1, ge2;
      always_comb begin
         sub        = div_ff[g].den << SH;
         ge1        = div_ff[g].rem1 >= sub;
         ge2        = div_ff[g].rem2 >= sub;
         div_in[g+1]      = div_ff[g];
         div_in[g+1].rem1 = ge1 ? div_ff[g].rem1 - sub : div_ff[g].rem1;
         div_in[g+1].rem2 = ge2 ? div_ff[g].rem2 - sub : div_ff[g].rem2;
         div_in[g+1].q1   = {div_ff[g].q1[CW-2:0], ge1};
         div_in[g+1].q2   = {div_ff[g].q2[CW-2:0], ge2};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i <= CW; i++) begin
            div_ff[i] <= div_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= CW; i++) begin
            dv_ff[i] <= 1'b0;
         end
      end else if (en) begin
         dv_ff[0] <= v8_ff;
         for (int i = 1; i <= CW; i++) begin
            dv_ff[i] <= dv_ff[i-1];
         end
      end
   end

   always_comb begin
      q1f    = div_ff[CW].q1;
      q2f    = div_ff[CW].q2;
      ovf_in = 1'b0;
      if (div_ff[CW].par) begin
         t1_in  = '0;
         t2_in  = div_ff[CW].par_t2;
         ovf_in = div_ff[CW].par_ovf;
      end else begin
         if (!div_ff[CW].neg1) begin
            if (div_ff[CW].big1 || q1f[CW-1]) begin
               t1_in  = cpl_pkg::SAT_MAX;
               ovf_in = 1'b1;
            end else begin
               t1_in = q1f;
            end
         end else begin
            if (div_ff[CW].big1 || q1f > cpl_pkg::SAT_MIN) begin
               t1_in  = cpl_pkg::SAT_MIN;
               ovf_in = 1'b1;
            end else begin
               t1_in = -q1f;
            end
         end
         if (!div_ff[CW].neg2) begin
            if (div_ff[CW].big2 || q2f[CW-1]) begin
               t2_in  = cpl_pkg::SAT_MAX;
               ovf_in = 1'b1;
            end else begin
               t2_in = q2f;
            end
         end else begin
            if (div_ff[CW].big2 || q2f > cpl_pkg::SAT_MIN) begin
               t2_in  = cpl_pkg::SAT_MIN;
               ovf_in = 1'b1;
            end else begin
               t2_in = -q2f;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t1_ff  <= t1_in;
         t2_ff  <= t2_in;
         par_ff <= div_ff[CW].par;
         ovf_ff <= ovf_in;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.param_first  = t1_ff;
   assign rsp.param_second = t2_ff;
   assign rsp.is_parallel  = par_ff;
   assign rsp.overflowed   = ovf_ff;

   a_par_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.is_parallel |-> rsp.param_first == '0)
      else $error("parallel response with nonzero first parameter");

   a_ovf_sat: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.overflowed |->
         rsp.param_first == cpl_pkg::SAT_MAX || rsp.param_first == cpl_pkg::SAT_MIN ||
         rsp.param_second == cpl_pkg::SAT_MAX || rsp.param_second == cpl_pkg::SAT_MIN)
      else $error("overflow flagged without a saturated parameter");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(v8_ff) && $stable(dv_ff[CW]) && $stable(vm_ff))
      else $error("pipeline advanced while stalled");

   a_thr_reset: assert property (@(posedge clock)
      reset |=> thr_ff == cpl_pkg::THR_RESET)
      else $error("threshold not restored by reset");
endmodule
`default_nettype wire

>>> verif/tb.sv
// Self-checking testbench for the closest-points block: predicts each response and compares.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = 42;
   localparam int LIMIT   = 400000;

   typedef logic [11:0][cpl_pkg::COORD_WIDTH-1:0] line_pair_type;
   typedef struct packed {
      logic [cpl_pkg::COORD_WIDTH-1:0] param_first;
      logic [cpl_pkg::COORD_WIDTH-1:0] param_second;
      logic                            is_parallel;
      logic                            overflowed;
   } line_params_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [cpl_pkg::CSR_AW-1:0] csr_paddr = '0;
   logic [cpl_pkg::CSR_DW-1:0] csr_pwdata = '0;
   logic [cpl_pkg::CSR_DW-1:0] csr_prdata;
   logic csr_pready;

   cpl_req_if req_if();
   cpl_rsp_if rsp_if();

   closest_points_two_lines_top u_top (
      .clock(clock), .reset(reset), .req(req_if.sink), .rsp(rsp_if.source),
      .psel(csr_psel), .penable(csr_penable), .pwrite(csr_pwrite), .paddr(csr_paddr),
      .pwdata(csr_pwdata), .prdata(csr_prdata), .pready(csr_pready)
   );

   logic [cpl_pkg::THR_WIDTH-1:0] threshold = cpl_pkg::THR_RESET;
   line_params_type expected_params[$];
   int mismatches = 0;
   int cycles = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;

   initial begin
      req_if.valid = 1'b0;
      req_if.first_point_x = '0;  req_if.first_point_y = '0;  req_if.first_point_z = '0;
      req_if.first_dir_x = '0;    req_if.first_dir_y = '0;    req_if.first_dir_z = '0;
      req_if.second_point_x = '0; req_if.second_point_y = '0; req_if.second_point_z = '0;
      req_if.second_dir_x = '0;   req_if.second_dir_y = '0;   req_if.second_dir_z = '0;
      rsp_if.ready = 1'b0;
   end

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic line_params_type closest_params(line_pair_type p,
                                                      logic [cpl_pkg::THR_WIDTH-1:0] thr);
      logic signed [255:0] r[3], a[3], b[3];
      logic signed [255:0] d11, d12, d22, r1, r2, det, lim, n1, n2, t1, t2;
      line_params_type res;
      for (int i = 0; i < 3; i++) begin
         r[i] = $signed(p[i]) - $signed(p[6+i]);
         a[i] = $signed(p[3+i]);
         b[i] = $signed(p[9+i]);
      end
      d11 = a[0]*a[0] + a[1]*a[1] + a[2]*a[2];
      d12 = a[0]*b[0] + a[1]*b[1] + a[2]*b[2];
      d22 = b[0]*b[0] + b[1]*b[1] + b[2]*b[2];
      r1  = a[0]*r[0] + a[1]*r[1] + a[2]*r[2];
      r2  = b[0]*r[0] + b[1]*r[1] + b[2]*r[2];
      det = d11*d22 - d12*d12;
      lim = 256'(thr) << (3*cpl_pkg::FRAC_BITS);
      if (det > lim) begin
         n1 = d12*r2 - d22*r1;
         n2 = d11*r2 - d12*r1;
         t1 = (n1 <<< cpl_pkg::FRAC_BITS) / det;
         t2 = (n2 <<< cpl_pkg::FRAC_BITS) / det;
         res.is_parallel = 1'b0;
      end else begin
         t1 = '0;
         t2 = r2 / 256'sd65536;
         res.is_parallel = 1'b1;
      end
      res.overflowed = 1'b0;
      if (t1 > 256'sd2147483647) begin
         t1 = 256'sd2147483647; res.overflowed = 1'b1;
      end else if (t1 < -256'sd2147483648) begin
         t1 = -256'sd2147483648; res.overflowed = 1'b1;
      end
      if (t2 > 256'sd2147483647) begin
         t2 = 256'sd2147483647; res.overflowed = 1'b1;
      end else if (t2 < -256'sd2147483648) begin
         t2 = -256'sd2147483648; res.overflowed = 1'b1;
      end
      res.param_first  = t1[cpl_pkg::COORD_WIDTH-1:0];
      res.param_second = t2[cpl_pkg::COORD_WIDTH-1:0];
      return res;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      line_params_type exp_p, got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = {rsp_if.param_first, rsp_if.param_second, rsp_if.is_parallel, rsp_if.overflowed};
         if (expected_params.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", got);
         end else begin
            exp_p = expected_params.pop_front();
            if (got !== exp_p) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: first exp %h got %h, second exp %h got %h, par %b/%b ovf %b/%b",
                           exp_p.param_first, got.param_first, exp_p.param_second,
                           got.param_second, exp_p.is_parallel, got.is_parallel,
                           exp_p.overflowed, got.overflowed);
            end
         end
      end
   end

   task automatic send_lines(line_pair_type p);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.first_point_x <= p[0];  req_if.first_point_y <= p[1];  req_if.first_point_z <= p[2];
      req_if.first_dir_x <= p[3];    req_if.first_dir_y <= p[4];    req_if.first_dir_z <= p[5];
      req_if.second_point_x <= p[6]; req_if.second_point_y <= p[7]; req_if.second_point_z <= p[8];
      req_if.second_dir_x <= p[9];   req_if.second_dir_y <= p[10];  req_if.second_dir_z <= p[11];
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      expected_params.push_back(closest_params(p, threshold));
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (expected_params.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_threshold(logic [cpl_pkg::CSR_DW-1:0] value);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= {cpl_pkg::REG_THRESHOLD, 2'b00}; csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      threshold = value[cpl_pkg::THR_WIDTH-1:0];
      csr_paddr <= {cpl_pkg::REG_THRESHOLD, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== {1'b0, threshold}) begin
         mismatches++;
         if (mismatches <= 10) $display("threshold readback exp %h got %h", threshold, csr_prdata);
      end
      csr_psel <= 1'b0; csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [cpl_pkg::COORD_WIDTH-1:0] rand_coord(int mode);
      case (mode)
         0: return $urandom;
         1: return $urandom_range(32'h0010_0000) - 32'h0008_0000;
         2: return $urandom_range(32'h0000_1000) - 32'h0000_0800;
         default:
            case ($urandom_range(4))
               0: return cpl_pkg::SAT_MAX;
               1: return cpl_pkg::SAT_MIN;
               2: return '0;
               3: return 32'hFFFF_FFFF;
               default: return 32'h0001_0000;
            endcase
      endcase
   endfunction

   function automatic line_pair_type rand_lines();
      line_pair_type p;
      int mode = $urandom_range(3);
      int k;
      for (int i = 0; i < 12; i++)
         p[i] = ($urandom_range(9) == 0) ? rand_coord($urandom_range(3)) : rand_coord(mode);
      case ($urandom_range(9))
         0: begin
            k = $urandom_range(6) - 3;
            for (int i = 0; i < 3; i++) p[9+i] = $signed(p[3+i]) * k;
         end
         1: for (int i = 0; i < 3; i++) p[9+i] = p[3+i] + $urandom_range(2) - 1;
         2: for (int i = 0; i < 3; i++) p[3+i] = '0;
         default: ;
      endcase
      return p;
   endfunction

   task automatic test_directed();
      line_pair_type p;
      p = '0; send_lines(p);
      for (int i = 0; i < 12; i++) p[i] = cpl_pkg::SAT_MAX;
      send_lines(p);
      for (int i = 0; i < 12; i++) p[i] = cpl_pkg::SAT_MIN;
      send_lines(p);
      for (int i = 0; i < 12; i++) p[i] = (i % 2) ? cpl_pkg::SAT_MAX : cpl_pkg::SAT_MIN;
      send_lines(p);
      for (int i = 0; i < 12; i++) p[i] = (i % 2) ? cpl_pkg::SAT_MIN : cpl_pkg::SAT_MAX;
      send_lines(p);
      p = '0; p[3] = 32'h0001_0000; p[10] = 32'h0001_0000;
      p[6] = 32'h0003_0000; p[1] = 32'hFFFE_0000; send_lines(p);
      p[8] = 32'h0005_0000; send_lines(p);
      p = '0; p[3] = 32'h0001_0000; p[9] = 32'h0002_0000; p[1] = 32'h0004_0000; send_lines(p);
      p = '0; p[3] = 1; p[10] = 1; p[0] = cpl_pkg::SAT_MAX; p[7] = cpl_pkg::SAT_MIN;
      send_lines(p);
      p = '0; p[3] = 32'h0000_0100; p[10] = 32'h0000_0100;
      p[1] = cpl_pkg::SAT_MAX; p[6] = cpl_pkg::SAT_MIN;
      send_lines(p);
      p = '0; p[9] = cpl_pkg::SAT_MIN; p[0] = cpl_pkg::SAT_MAX; p[6] = cpl_pkg::SAT_MIN;
      send_lines(p);
      p = '0; p[3] = cpl_pkg::SAT_MAX; p[4] = cpl_pkg::SAT_MAX;
      p[9] = cpl_pkg::SAT_MAX; p[10] = cpl_pkg::SAT_MIN;
      p[2] = 32'h1234_5678; send_lines(p);
      drain();
      write_threshold(32'h0000_0000);
      p = '0; p[3] = 1; p[10] = 1; p[0] = 32'h0100_0000; p[7] = 32'h0100_0000; send_lines(p);
      p = '0; p[3] = 32'h0001_0000; p[10] = 32'h0001_0000; p[0] = 32'h0002_0000; send_lines(p);
      p = '0; send_lines(p);
      drain();
      write_threshold(32'hFFFF_FFFF);
      p = '0; p[3] = cpl_pkg::SAT_MAX; p[10] = cpl_pkg::SAT_MAX; p[0] = 32'h0007_0000;
      send_lines(p);
      p = '0; p[3] = 32'h0001_0000; p[10] = 32'h0001_0000; p[8] = cpl_pkg::SAT_MAX;
      send_lines(p);
      drain();
   endtask

   task automatic test_random();
      logic [cpl_pkg::CSR_DW-1:0] thr_set[5];
      thr_set[0] = 32'h0000_0001; thr_set[1] = 32'h0000_0000; thr_set[2] = 32'h7FFF_FFFF;
      thr_set[3] = $urandom; thr_set[4] = $urandom_range(32'h0001_0000);
      for (int ph = 0; ph < 5; ph++) begin
         write_threshold(thr_set[ph]);
         case (ph)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 85; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 85; end
            3: begin send_idle_pct = 9;  stall_pct = 9;  end
            default: begin send_idle_pct = $urandom_range(50); stall_pct = $urandom_range(50); end
         endcase
         for (int n = 0; n < 90; n++) begin
            send_lines(rand_lines());
            if (n == 45) drain();
         end
         drain();
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random();
      if (mismatches == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end
endmodule

>>> filelist.f
rtl/cpl_pkg.sv
rtl/cpl_req_if.sv
rtl/cpl_rsp_if.sv
rtl/cpl_mul.sv
rtl/closest_points_two_lines_top.sv
verif/tb.sv
